// ===== src/olbs_pkg.sv =====
// Package with the shared constants, command codes and types of the occupied-level bitmap search.
`default_nettype none
package olbs_pkg;

  localparam int unsigned LEVELS      = 1024;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned OCC_WORDS   = (LEVELS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned LEVEL_W     = 10;
  localparam int unsigned BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int unsigned WORD_IDX_W  = (OCC_WORDS > 1) ? $clog2(OCC_WORDS) : 1;
  localparam int unsigned LEVEL_BITS  = $clog2(LEVELS);
  localparam int unsigned CALC_W      = ((LEVEL_W > LEVEL_BITS) ? LEVEL_W : LEVEL_BITS) + 1;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_ABOVE = 2'd2,
    CMD_BELOW = 2'd3
  } cmd_e;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic  en;
    word_t data;
  } bm_wr_t;

  typedef struct packed {
    logic                 any;
    logic [BIT_IDX_W-1:0] idx;
  } enc_res_t;

endpackage
`default_nettype wire

// ===== src/olbs_bitmap.sv =====
// Occupancy bitmap word store with one shared address for read and write.
`default_nettype none
module olbs_bitmap (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [olbs_pkg::WORD_IDX_W-1:0] addr_i,
  input  wire olbs_pkg::bm_wr_t               wr_i,
  output olbs_pkg::word_t                     rd_data_o
);
  import olbs_pkg::*;

  word_t words_q [OCC_WORDS];

  assign rd_data_o = words_q[addr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(OCC_WORDS); i++) begin
        words_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      words_q[addr_i] <= wr_i.data;
    end
  end

endmodule
`default_nettype wire

// ===== src/olbs_prienc.sv =====
// Priority encoder that finds the lowest or the highest set bit of one bitmap word.
`default_nettype none
module olbs_prienc (
  input  wire olbs_pkg::word_t    word_i,
  input  wire logic               high_first_i,
  output olbs_pkg::enc_res_t      res_o
);
  import olbs_pkg::*;

  logic [BIT_IDX_W-1:0] low_idx;
  logic [BIT_IDX_W-1:0] high_idx;

  always_comb begin
    low_idx  = '0;
    high_idx = '0;
    for (int i = int'(WORD_BITS) - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        low_idx = BIT_IDX_W'(i);
      end
    end
    for (int i = 0; i < int'(WORD_BITS); i++) begin
      if (word_i[i]) begin
        high_idx = BIT_IDX_W'(i);
      end
    end
    res_o.any = |word_i;
    res_o.idx = high_first_i ? high_idx : low_idx;
  end

endmodule
`default_nettype wire

// ===== src/occupied_level_bitmap_search.sv =====
// Top level of the occupied-level bitmap search: command sequencer, word scan and result register.
//
//   port group   direction  handshake              payload
//   command      in         start_i while !busy_o  command_i, level_i
//   result       out        done_o for one cycle   found_o, found_level_o
//
// Mark and clear update the word when the command is taken; the result follows in the next cycle.
// A search is set up when the command is taken and then scans one bitmap word per cycle through the
// single word read port and the shared priority encoder.
// A search with nothing to scan, above the top level or below level zero, answers in the next cycle.
// The reset clears every bitmap word at once, so commands are taken from the first cycle.
// The result is shown for one cycle and the receiver cannot stall it.
`default_nettype none
module occupied_level_bitmap_search (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [1:0]                    command_i,
  input  wire logic [olbs_pkg::LEVEL_W-1:0]  level_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic                               found_o,
  output logic [olbs_pkg::LEVEL_W-1:0]       found_level_o
);
  import olbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [WORD_IDX_W-1:0] ptr_q, ptr_d;
  word_t                 mask_q, mask_d;
  logic                  down_q, down_d;
  logic                  done_q, done_d;
  logic                  found_q, found_d;
  logic [LEVEL_W-1:0]    flevel_q, flevel_d;

  logic                  accept;
  cmd_e                  cmd_in;
  logic [WORD_IDX_W-1:0] addr;
  bm_wr_t                wr;
  word_t                 rd_data;
  word_t                 bit_mask;
  logic                  in_range;
  logic [CALC_W-1:0]     start_lvl;
  logic [CALC_W-1:0]     hit_lvl;
  logic [WORD_IDX_W-1:0] last_ptr;
  enc_res_t              enc;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign cmd_in   = cmd_e'(command_i);
  assign in_range = CALC_W'(level_i) < CALC_W'(LEVELS);
  assign bit_mask = word_t'(1) << level_i[BIT_IDX_W-1:0];
  assign addr     = (state_q == ST_SCAN) ? ptr_q : WORD_IDX_W'(level_i >> BIT_IDX_W);
  assign last_ptr = down_q ? '0 : WORD_IDX_W'(OCC_WORDS - 1);
  assign hit_lvl  = CALC_W'({ptr_q, enc.idx});

  olbs_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .addr_i    (addr),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  olbs_prienc u_prienc (
    .word_i       (rd_data & mask_q),
    .high_first_i (down_q),
    .res_o        (enc)
  );

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    mask_d    = mask_q;
    down_d    = down_q;
    done_d    = 1'b0;
    found_d   = 1'b0;
    flevel_d  = '0;
    wr.en     = 1'b0;
    wr.data   = (cmd_in == CMD_MARK) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    start_lvl = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_MARK, CMD_CLEAR: begin
              wr.en  = in_range;
              done_d = 1'b1;
            end
            CMD_ABOVE: begin
              start_lvl = CALC_W'(level_i) + CALC_W'(1);
              down_d    = 1'b0;
              if (start_lvl >= CALC_W'(LEVELS)) begin
                done_d = 1'b1;
              end else begin
                ptr_d   = WORD_IDX_W'(start_lvl >> BIT_IDX_W);
                mask_d  = ~word_t'(0) << start_lvl[BIT_IDX_W-1:0];
                state_d = ST_SCAN;
              end
            end
            default: begin
              start_lvl = CALC_W'(level_i) - CALC_W'(1);
              down_d    = 1'b1;
              if (start_lvl >= CALC_W'(LEVELS)) begin
                start_lvl = CALC_W'(LEVELS - 1);
              end
              if (level_i == '0) begin
                done_d = 1'b1;
              end else begin
                ptr_d   = WORD_IDX_W'(start_lvl >> BIT_IDX_W);
                mask_d  = ~word_t'(0) >> (BIT_IDX_W'(WORD_BITS - 1) -
                                          start_lvl[BIT_IDX_W-1:0]);
                state_d = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        mask_d = ~word_t'(0);
        if (enc.any) begin
          done_d   = 1'b1;
          found_d  = 1'b1;
          flevel_d = hit_lvl[LEVEL_W-1:0];
          state_d  = ST_IDLE;
        end else if (ptr_q == last_ptr) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ptr_d = down_q ? (ptr_q - WORD_IDX_W'(1)) : (ptr_q + WORD_IDX_W'(1));
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    mask_q   <= mask_d;
    down_q   <= down_d;
    flevel_q <= flevel_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign found_level_o = flevel_q;

endmodule
`default_nettype wire

// ===== src/olbs_checker.sv =====
// Port-level checks of the occupied-level bitmap search and their bind to the top level.
`default_nettype none
module olbs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic [1:0]                    command_i,
  input wire logic                          busy_o,
  input wire logic                          done_o,
  input wire logic                          found_o,
  input wire logic [olbs_pkg::LEVEL_W-1:0]  found_level_o
);
  import olbs_pkg::*;

  logic take;
  assign take = start_i && !busy_o;

  a_found_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> done_o) else $error("found without a result strobe");

  a_miss_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (found_level_o == '0)) else $error("miss with a level");

  a_update_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (command_i == CMD_MARK || command_i == CMD_CLEAR)) |=> (done_o && !found_o))
    else $error("mark or clear word did not finish in one cycle");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy while a result is shown");

  a_search_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (command_i == CMD_ABOVE || command_i == CMD_BELOW)) |=> (busy_o || done_o))
    else $error("search word dropped");

endmodule

bind occupied_level_bitmap_search olbs_checker u_olbs_checker (.*);
`default_nettype wire
